>>> rtl/stk_pkg.sv
// Shared types and codes for the bounded stack with search and mean count.
package stk_pkg;

    // Operation carried on the input tuser
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_MEAN   = 2'd2,
        OP_LOCATE = 2'd3
    } op_t;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESULT
    } ctrl_state_t;

    // Scan engine modes
    typedef enum logic [1:0] {
        SCAN_LOCATE,
        SCAN_SUM,
        SCAN_CMP
    } scan_mode_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic scan_start;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic scan_busy;
    } dp_stat_t;

endpackage

>>> rtl/stk_ctrl.sv
// Controller state machine: sequences accept, execute, scan and result beats.
module stk_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output stk_pkg::dp_cmd_t  cmd,
    input  stk_pkg::dp_stat_t stat
);
    import stk_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.op == OP_MEAN || stat.op == OP_LOCATE)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_busy)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.push       = (stat.op == OP_PUSH);
                cmd.pop        = (stat.op == OP_POP);
                cmd.scan_start = (stat.op == OP_MEAN || stat.op == OP_LOCATE);
            end
            S_SCAN:
            begin
                cmd = '0;
            end
            S_RESULT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/stk_dp.sv
// Datapath: entry memory, occupancy counter, scan engine for locate and mean count.
module stk_dp
#(
    parameter  int DEPTH      = 256,
    parameter  int DATA_WIDTH = 32,
    localparam int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  stk_pkg::dp_cmd_t        cmd,
    output stk_pkg::dp_stat_t       stat,
    input  stk_pkg::op_t            in_op,
    input  logic [DATA_WIDTH-1:0]   in_value,
    output logic [DATA_WIDTH-1:0]   popped_value,
    output logic [CW-1:0]           answer,
    output stk_pkg::status_t        status,
    output logic [CW-1:0]           occupancy
);
    import stk_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = DATA_WIDTH + CW;
    localparam int PROD_W = DATA_WIDTH + CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Entry memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Control state
    logic [CW-1:0]  count_reg;
    logic           active_reg;
    scan_mode_t     mode_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           pop_ok_reg;

    // Payload state
    op_t                    op_reg;
    logic [DATA_WIDTH-1:0]  key_reg;
    logic [CW-1:0]          ans_reg;
    status_t                status_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          pos1_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                   full;
    logic                   empty;
    logic                   issue;
    logic                   issue_done;
    logic                   match;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [CW-1:0]          count_m1;
    logic [CW-1:0]          loc_idx;
    logic signed [PROD_W-1:0] mul_w;
    logic signed [PROD_W-1:0] sum_ext;
    logic signed [SUM_W-1:0]  rd_ext;

    assign full       = (count_reg == DEPTH_C);
    assign empty      = (count_reg == '0);
    assign count_m1   = count_reg - ONE_C;
    assign loc_idx    = count_reg - idx_reg - ONE_C;
    assign issue_done = (idx_reg == count_reg);
    assign issue      = active_reg && !issue_done;
    assign match      = v1_reg && (rd_data_reg == key_reg);

    // Read address: pop reads the top, scans walk up or down the stack
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = count_m1[AW-1:0];
        if (cmd.pop && !empty)
        begin
            rd_en   = 1'b1;
            rd_addr = count_m1[AW-1:0];
        end
        else if (issue)
        begin
            rd_en = 1'b1;
            if (mode_reg == SCAN_LOCATE)
            begin
                rd_addr = loc_idx[AW-1:0];
            end
            else
            begin
                rd_addr = idx_reg[AW-1:0];
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            mem[count_reg[AW-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Mean test arithmetic
    assign rd_ext  = {{CW{rd_data_reg[DATA_WIDTH-1]}}, rd_data_reg};
    assign mul_w   = $signed({{(PROD_W - DATA_WIDTH){rd_data_reg[DATA_WIDTH-1]}}, rd_data_reg})
                   * $signed({{(PROD_W - CW){1'b0}}, count_reg});
    assign sum_ext = {{(PROD_W - SUM_W){sum_reg[SUM_W-1]}}, sum_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            active_reg <= 1'b0;
            mode_reg   <= SCAN_LOCATE;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                pop_ok_reg <= 1'b0;
            end
            if (cmd.push && !full)
            begin
                count_reg <= count_reg + ONE_C;
            end
            if (cmd.pop && !empty)
            begin
                count_reg  <= count_m1;
                pop_ok_reg <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                active_reg <= 1'b1;
                v1_reg     <= 1'b0;
                v2_reg     <= 1'b0;
                mode_reg   <= (op_reg == OP_LOCATE) ? SCAN_LOCATE : SCAN_SUM;
            end
            else if (active_reg)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg && (mode_reg == SCAN_CMP);
                case (mode_reg)
                    SCAN_LOCATE:
                    begin
                        if (match || (issue_done && !v1_reg))
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                    SCAN_SUM:
                    begin
                        if (issue_done && !v1_reg)
                        begin
                            mode_reg <= SCAN_CMP;
                        end
                    end
                    SCAN_CMP:
                    begin
                        if (issue_done && !v1_reg && !v2_reg)
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                        active_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            key_reg    <= in_value;
            ans_reg    <= '0;
            status_reg <= STS_OK;
        end
        if (cmd.push && full)
        begin
            status_reg <= STS_FULL;
        end
        if (cmd.pop && empty)
        begin
            status_reg <= STS_EMPTY;
        end
        if (cmd.scan_start)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (active_reg)
        begin
            pos1_reg <= idx_reg;
            if (issue)
            begin
                idx_reg <= idx_reg + ONE_C;
            end
            case (mode_reg)
                SCAN_LOCATE:
                begin
                    if (match)
                    begin
                        ans_reg <= pos1_reg + ONE_C;
                    end
                end
                SCAN_SUM:
                begin
                    if (v1_reg)
                    begin
                        sum_reg <= sum_reg + rd_ext;
                    end
                    if (issue_done && !v1_reg)
                    begin
                        idx_reg <= '0;
                    end
                end
                SCAN_CMP:
                begin
                    if (v1_reg)
                    begin
                        prod_reg <= mul_w;
                    end
                    if (v2_reg && (prod_reg > sum_ext))
                    begin
                        ans_reg <= ans_reg + ONE_C;
                    end
                end
                default:
                begin
                    ans_reg <= ans_reg;
                end
            endcase
        end
    end

    // Status and result fields
    assign stat.op        = op_reg;
    assign stat.scan_busy = active_reg;
    assign popped_value   = pop_ok_reg ? rd_data_reg : '0;
    assign answer         = ans_reg;
    assign status         = status_reg;
    assign occupancy      = count_reg;

endmodule

>>> rtl/stack_with_search_and_mean_count_top.sv
// Top level of the bounded stack with search and mean count.
//
// Input channel s_axis: one beat per operation. tuser carries the operation
// (push, pop, count above mean, locate), tdata the value to push or the key.
// Output channel m_axis: exactly one beat per input beat, carrying the popped
// value, the answer and the occupancy in tdata and the status in tuser.
// One operation is in flight at a time; s_axis_tready is high only while idle.
// Each operation is accepted in idle, then executed, then held as a result beat;
// locate and count above mean pass through a scan between execute and result.
// Locate ends early on a match.
// The next beat is taken in the cycle after the result beat is taken.
// The scans are set by the single read port of the entry memory, which
// visits one entry per cycle: once for locate, twice (sum, then compare)
// for the mean count.
// Reset empties the stack at once; memory contents are not cleared.
// A stalled result holds on m_axis until taken; no new beat is accepted
// meanwhile.
module stack_with_search_and_mean_count_top
#(
    parameter  int DEPTH      = 256,
    parameter  int DATA_WIDTH = 32,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((DATA_WIDTH + 2 * CW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // operand_value
    input  logic [1:0]       s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // popped_value, answer, occupancy
    output logic [1:0]       m_axis_tuser    // status
);
    import stk_pkg::*;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [DATA_WIDTH-1:0] popped_value;
    logic [CW-1:0]         answer;
    status_t               status;
    logic [CW-1:0]         occupancy;

    stk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    stk_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (op_t'(s_axis_tuser)),
        .in_value     (s_axis_tdata[DATA_WIDTH-1:0]),
        .popped_value (popped_value),
        .answer       (answer),
        .status       (status),
        .occupancy    (occupancy)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = OUT_W'({occupancy, answer, popped_value});
    assign m_axis_tuser = status;

endmodule

>>> rtl/stk_chk.sv
// Port-level checker for the stack top level, attached by bind.
module stk_chk
#(
    parameter  int DEPTH      = 256,
    parameter  int DATA_WIDTH = 32,
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int OUT_W      = ((DATA_WIDTH + 2 * CW + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);
    import stk_pkg::*;

    logic [DATA_WIDTH-1:0] popped;
    logic [CW-1:0]         ans;
    logic [CW-1:0]         occ;

    assign popped = m_axis_tdata[DATA_WIDTH-1:0];
    assign ans    = m_axis_tdata[DATA_WIDTH+CW-1:DATA_WIDTH];
    assign occ    = m_axis_tdata[DATA_WIDTH+2*CW-1:DATA_WIDTH+CW];

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // No input beat is taken while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // Full status only at full occupancy, empty status only when empty with nothing popped
    a_status_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != STS_FULL || occ == CW'(DEPTH))
            && (m_axis_tuser != STS_EMPTY || (occ == '0 && popped == '0)))
        else $error("status disagrees with occupancy");

    // Occupancy bounded, and answers never exceed it
    a_answer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> occ <= CW'(DEPTH) && ans <= occ)
        else $error("answer or occupancy out of range");

endmodule

bind stack_with_search_and_mean_count_top stk_chk #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_stk_chk (.*);

>>> bench/tb.sv
// Self-checking bench for the stack with search and mean count: directed edge cases plus random fill and drain.
module tb;
    import stk_pkg::*;

    localparam int STACK_DEPTH  = 256;
    localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 600;   // longer than a full-stack mean count
    localparam int PHASE_ITEMS  = 150;

    // Idle/stall pacing phases
    typedef enum int {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } pace_t;

    // One expected result beat
    typedef struct packed {
        logic [31:0] popped;
        logic [8:0]  answer;
        status_t     status;
        logic [8:0]  occupancy;
    } stack_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // operand_value
    logic [1:0]  s_axis_tuser;    // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;    // popped_value, answer, occupancy
    logic [1:0]  m_axis_tuser;    // status

    // Shadow stack state
    logic [31:0]   shadow_entries [0:STACK_DEPTH-1];
    int            shadow_count;
    stack_result_t pending_stack_results [$];

    int    error_count;
    int    sent_count;
    int    quiet_cycles;
    pace_t pace;
    int    sender_idle_pct;
    int    receiver_stall_pct;

    stack_with_search_and_mean_count_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Apply one operation to the shadow stack and return the result it yields
    function automatic stack_result_t apply_stack_op(op_t op, logic [31:0] operand);
        stack_result_t r;
        longint        sum;
        longint        word;
        r = '0;
        r.status = STS_OK;
        case (op)
            OP_PUSH:
            begin
                if (shadow_count >= STACK_DEPTH)
                    r.status = STS_FULL;
                else
                begin
                    shadow_entries[shadow_count] = operand;
                    shadow_count++;
                end
            end
            OP_POP:
            begin
                if (shadow_count == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    shadow_count--;
                    r.popped = shadow_entries[shadow_count];
                end
            end
            OP_MEAN:
            begin
                // value * count > sum, exact in 64 bits
                sum = 0;
                for (int i = 0; i < shadow_count; i++)
                    sum += longint'($signed(shadow_entries[i]));
                for (int i = 0; i < shadow_count; i++)
                begin
                    word = longint'($signed(shadow_entries[i]));
                    if (word * shadow_count > sum)
                        r.answer++;
                end
            end
            default:
            begin
                // search from the top, nearest match wins
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (r.answer == 0 && shadow_entries[shadow_count - 1 - i] == operand)
                        r.answer = 9'(i + 1);
                end
            end
        endcase
        r.occupancy = 9'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic set_pace(pace_t p);
        pace = p;
        sender_idle_pct    = (p == PACE_SENDER) ? 67 : (p == PACE_BOTH) ? 21 : 0;
        receiver_stall_pct = (p == PACE_RECEIVER) ? 67 : (p == PACE_BOTH) ? 21 : 0;
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stack_results.size() != 0);
    endtask

    // Send one beat, with random idle cycles ahead of it
    task automatic send_op(op_t op, logic [31:0] operand);
        if (sent_count > 0 && sent_count % PHASE_ITEMS == 0)
        begin
            wait_for_results();
            set_pace(pace_t'((int'(pace) + 1) % 4));
        end
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_stack_results.push_back(apply_stack_op(op, operand));
        sent_count++;
    endtask

    // Word to push: extremes, a small pool for duplicates and ties, or anything
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2, 3: return 32'($signed($urandom_range(7)) - 4);
            default: return $urandom();
        endcase
    endfunction

    // Key to locate: mostly a held word, else any word
    function automatic logic [31:0] pick_key();
        if (shadow_count > 0 && $urandom_range(9) < 6)
            return shadow_entries[$urandom_range(shadow_count - 1)];
        return pick_word();
    endfunction

    // One random operation from the given percentage weights
    task automatic send_random_op(int push_pct, int pop_pct, int mean_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            send_op(OP_PUSH, pick_word());
        else if (roll < push_pct + pop_pct)
            send_op(OP_POP, $urandom());
        else if (roll < push_pct + pop_pct + mean_pct)
            send_op(OP_MEAN, $urandom());
        else
            send_op(OP_LOCATE, pick_key());
    endtask

    // Refusals and searches on an empty stack
    task automatic test_empty_stack;
        send_op(OP_POP, 32'hFFFF_FFFF);
        send_op(OP_MEAN, 32'h0);
        send_op(OP_LOCATE, 32'h0);
    endtask

    // Signed extremes, duplicate keys and an all-equal mean
    task automatic test_extremes_and_duplicates;
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h0000_0000);
        send_op(OP_PUSH, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_LOCATE, 32'h8000_0000);
        send_op(OP_LOCATE, 32'h7FFF_FFFF);
        send_op(OP_LOCATE, 32'd12345);
        send_op(OP_MEAN, 32'hA5A5_A5A5);
        repeat (5)
            send_op(OP_POP, $urandom());
        wait_for_results();
        repeat (3)
            send_op(OP_PUSH, 32'd7);
        send_op(OP_MEAN, 32'd0);
        repeat (3)
            send_op(OP_POP, 32'd0);
        send_op(OP_POP, 32'd0);
    endtask

    // Grow to full, then refused pushes and full-depth scans
    task automatic test_fill_to_full;
        while (shadow_count < STACK_DEPTH)
            send_random_op(94, 2, 2);
        repeat (3)
            send_op(OP_PUSH, pick_word());
        send_op(OP_MEAN, $urandom());
        send_op(OP_LOCATE, shadow_entries[0]);
        send_op(OP_LOCATE, pick_key());
        send_op(OP_PUSH, $urandom());
    endtask

    // Shrink back to empty, then refusals once more
    task automatic test_drain_to_empty;
        while (shadow_count > 0)
            send_random_op(2, 94, 2);
        send_op(OP_POP, $urandom());
        send_op(OP_MEAN, $urandom());
        send_op(OP_LOCATE, $urandom());
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_stack_results.size() == 0)
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'h0);
            else
            begin
                stack_result_t want;
                want = pending_stack_results.pop_front();
                if (m_axis_tdata[31:0] !== want.popped)
                    report_mismatch("popped_value", m_axis_tdata[31:0], want.popped);
                if (m_axis_tdata[40:32] !== want.answer)
                    report_mismatch("answer", 32'(m_axis_tdata[40:32]), 32'(want.answer));
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[49:41] !== want.occupancy)
                    report_mismatch("occupancy", 32'(m_axis_tdata[49:41]),
                                    32'(want.occupancy));
            end
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Test sequence
    initial
    begin
        sent_count   = 0;
        shadow_count = 0;
        set_pace(PACE_NONE);
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUSH;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_extremes_and_duplicates();
        test_fill_to_full();
        test_drain_to_empty();

        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0 && pending_stack_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
